// File: src/tsm_pkg.sv
// Shared constants and types for the timed sign-magnitude frame sender.
package tsm_pkg;

  localparam int VALUE_W   = 20;
  localparam int UNIT_W    = 16;
  localparam int TICKS_W   = 20;
  localparam int STATUS_W  = 2;
  localparam int MAG_W     = 12;
  localparam int DATA_BITS = 12;
  localparam int BIDX_W    = 4;
  localparam int DVEC_W    = 1 << BIDX_W;

  localparam logic [STATUS_W-1:0] ST_TICK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SENT      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE_ERR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BUSY_ERR  = 2'd3;

  typedef struct packed {
    logic                line_level;
    logic [STATUS_W-1:0] status;
    logic                busy_res;
  } result_t;

endpackage

// File: src/tsm_req_if.sv
// Request channel: op and value words with valid/ready handshake.
interface tsm_req_if;
  import tsm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

// File: src/tsm_rsp_if.sv
// Result channel: line level, status and busy words with valid/ready handshake.
interface tsm_rsp_if;
  import tsm_pkg::*;

  logic                valid;
  logic                ready;
  logic                line_level;
  logic [STATUS_W-1:0] status;
  logic                busy_res;

  modport source (output valid, output line_level, output status, output busy_res,
                  input ready);
  modport sink (input valid, input line_level, input status, input busy_res,
                output ready);
endinterface

// File: src/timed_sign_magnitude_frame_sender.sv
// Timed sign-magnitude frame sender: request handling, frame timing and result queue.
//
// Every request word produces exactly one result word, and one request word is
// taken per clock while the queue has room. The frame state updates in the cycle
// a word is accepted and the result goes into a two-entry output queue, so input
// ready drops only when both queue entries wait on the result side. The magnitude
// conversion runs in a two-stage multiplier pipeline (scale by 10000, then divide
// by 10 through a reciprocal multiply); a sent value passes mag_q, t5_q and
// magnitude_bits long before the data bits go out. A phase length is taken from
// unit_ticks when the phase starts; a unit_ticks of zero counts as one.
module timed_sign_magnitude_frame_sender (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [tsm_pkg::UNIT_W-1:0] cfg_data,
  tsm_req_if.sink                 req,
  tsm_rsp_if.source               rsp
);
  import tsm_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_GAP   = 3'd2;
  localparam logic [2:0] PH_SIGN  = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;

  localparam logic [VALUE_W:0]       LIMIT_Q16 = (VALUE_W+1)'(262144);
  localparam logic [BIDX_W:0]        LAST_BIT  = (BIDX_W+1)'(DATA_BITS);

  logic [UNIT_W-1:0]  unit_ticks;
  logic [2:0]         phase, phase_next;
  logic [BIDX_W-1:0]  bit_index, bit_index_next;
  logic [TICKS_W-1:0] ticks_left, ticks_left_next;
  logic               sign_bit, sign_bit_next;
  logic               line_reg, line_reg_next;
  logic [STATUS_W-1:0] status_next;
  logic               mag_load;

  logic [18:0]        mag_q;
  logic [15:0]        t5_q;
  logic [MAG_W-1:0]   magnitude_bits;

  logic               neg;
  logic [VALUE_W:0]   mag;
  logic [UNIT_W-1:0]  unit;
  logic [TICKS_W-1:0] len10, len15;
  logic [BIDX_W:0]    bit_inc;
  logic [DVEC_W-1:0]  data_vec;
  logic [32:0]        prod_scale;
  logic [32:0]        prod_div;

  result_t            res_new;
  result_t            q0, q1;
  logic [1:0]         count;
  logic               push, pop;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_W'(1);
    end else if (cfg_we) begin
      unit_ticks <= cfg_data;
    end
  end

  assign unit  = (unit_ticks == '0) ? UNIT_W'(1) : unit_ticks;
  assign len10 = ({4'b0, unit} << 3) + ({4'b0, unit} << 1);
  assign len15 = ({4'b0, unit} << 4) - {4'b0, unit};

  assign neg = req.value[VALUE_W-1];
  assign mag = neg ? ((VALUE_W+1)'(1 << VALUE_W) - {1'b0, req.value})
                   : {1'b0, req.value};

  assign data_vec = {{(DVEC_W-MAG_W){1'b0}}, magnitude_bits};
  assign bit_inc  = {1'b0, bit_index} + (BIDX_W+1)'(1);

  always_comb begin
    phase_next      = phase;
    bit_index_next  = bit_index;
    ticks_left_next = ticks_left;
    sign_bit_next   = sign_bit;
    line_reg_next   = line_reg;
    status_next     = ST_TICK;
    mag_load        = 1'b0;
    if (!req.op) begin
      if (phase != PH_IDLE) begin
        if (ticks_left > TICKS_W'(1)) begin
          ticks_left_next = ticks_left - TICKS_W'(1);
        end else begin
          unique case (phase)
            PH_START: begin
              phase_next      = PH_GAP;
              line_reg_next   = 1'b0;
              ticks_left_next = len10;
            end
            PH_GAP: begin
              phase_next      = PH_SIGN;
              line_reg_next   = sign_bit;
              ticks_left_next = len10;
            end
            PH_SIGN: begin
              phase_next      = PH_DATA;
              bit_index_next  = '0;
              line_reg_next   = data_vec[0];
              ticks_left_next = len10;
            end
            PH_DATA: begin
              if (bit_inc < LAST_BIT) begin
                bit_index_next  = bit_inc[BIDX_W-1:0];
                line_reg_next   = data_vec[bit_inc[BIDX_W-1:0]];
                ticks_left_next = len10;
              end else begin
                phase_next      = PH_IDLE;
                bit_index_next  = '0;
                line_reg_next   = 1'b0;
                ticks_left_next = '0;
              end
            end
            default: begin
              phase_next      = PH_IDLE;
              line_reg_next   = 1'b0;
              ticks_left_next = '0;
            end
          endcase
        end
      end
    end else begin
      priority if (mag > LIMIT_Q16) begin
        status_next = ST_RANGE_ERR;
      end else if (phase != PH_IDLE) begin
        status_next = ST_BUSY_ERR;
      end else begin
        status_next     = ST_SENT;
        mag_load        = 1'b1;
        sign_bit_next   = neg;
        phase_next      = PH_START;
        bit_index_next  = '0;
        line_reg_next   = 1'b1;
        ticks_left_next = len15;
      end
    end
  end

  assign push = req.valid && req.ready;
  assign pop  = rsp.valid && rsp.ready;

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      bit_index  <= '0;
      ticks_left <= '0;
      sign_bit   <= 1'b0;
      line_reg   <= 1'b0;
    end else if (push) begin
      phase      <= phase_next;
      bit_index  <= bit_index_next;
      ticks_left <= ticks_left_next;
      sign_bit   <= sign_bit_next;
      line_reg   <= line_reg_next;
    end
  end

  // Magnitude pipeline: scale to ten-thousandths, then round half-up to thousandths
  assign prod_scale = 33'(mag_q) * 33'(14'd10000);
  assign prod_div   = 33'(t5_q) * 33'(17'd52429);

  always_ff @(posedge clk) begin
    if (push && mag_load) begin
      mag_q <= mag[18:0];
    end
    t5_q           <= prod_scale[31:16] + 16'd5;
    magnitude_bits <= prod_div[30:19];
  end

  // Result queue
  assign res_new.line_level = line_reg_next;
  assign res_new.status     = status_next;
  assign res_new.busy_res   = (phase_next != PH_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          q0 <= res_new;
        end else begin
          q1 <= res_new;
        end
      end
      2'b01: begin
        q0 <= q1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          q0 <= res_new;
        end else begin
          q0 <= q1;
          q1 <= res_new;
        end
      end
      default: begin
        q0 <= q0;
      end
    endcase
  end

  assign req.ready      = (count != 2'd2);
  assign rsp.valid      = (count != 2'd0);
  assign rsp.line_level = q0.line_level;
  assign rsp.status     = q0.status;
  assign rsp.busy_res   = q0.busy_res;

endmodule
